// ===== src/ole_pkg.sv =====
`default_nettype none
package ole_pkg;

   typedef enum logic [2:0] {
      OP_TAIL_INSERT = 3'd0,
      OP_HEAD_REMOVE = 3'd1,
      OP_POS_INSERT  = 3'd2,
      OP_REMOVE_VAL  = 3'd3,
      OP_REMOVE_MAX  = 3'd4,
      OP_MIN         = 3'd5
   } op_type;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_BADPOS   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_DOWN,
      S_SHIFT_UP,
      S_WRITE,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request
      logic scan_start;
      logic scan_step;
      logic down_start; // close gap at hit index
      logic up_start;   // open gap at insert index
      logic shift_step;
      logic write_new;
      logic resp_load;
      logic [2:0] status;
      logic use_value;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic pos_ok;
      logic scan_done;
      logic found;
      logic shift_done;
   } stat_type;

endpackage
`default_nettype wire

// ===== src/ole_if.sv =====
`default_nettype none
interface ole_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic signed [31:0] item_value;
   logic [6:0]  position;
   modport source (output valid, operation, item_value, position, input ready);
   modport sink (input valid, operation, item_value, position, output ready);
endinterface

interface ole_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic signed [31:0] result_value;
   logic [6:0]  entry_count;
   modport source (output valid, status, result_value, entry_count, input ready);
   modport sink (input valid, status, result_value, entry_count, output ready);
endinterface
`default_nettype wire

// ===== src/ole_ram.sv =====
`default_nettype none
module ole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/ole_datapath.sv =====
`default_nettype none
module ole_datapath #(
   parameter int CAPACITY = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ole_pkg::cmd_type  cmd,
   output ole_pkg::stat_type      stat,
   input  wire logic [2:0]        req_operation,
   input  wire logic [31:0]       req_item_value,
   input  wire logic [6:0]        req_position,
   output logic [2:0]             rsp_status,
   output logic [31:0]            rsp_result_value,
   output logic [6:0]             rsp_entry_count
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 7) ? CW + 1 : 8;

   logic [CW-1:0] len_ff, len_in;
   logic [2:0]    op_ff;
   logic [31:0]   val_ff;
   logic [6:0]    pos_ff;
   logic [CW-1:0] idx_ff, idx_in;   // scan pointer / shift pointer
   logic [CW-1:0] hit_ff, hit_in;   // found or best index
   logic [31:0]   best_ff, best_in;
   logic          found_ff, found_in;
   logic          last_ff, last_in; // last scanned entry taken
   logic          rd_ok_ff;         // read data valid (for idx_ff-1 in scan and shift up, for idx_ff in shift down)
   logic [CW-1:0] stop_ff;
   logic [2:0]    st_ff;
   logic [31:0]   res_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;

   ole_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_comb begin
      stat.empty      = (len_ff == '0);
      stat.full       = (len_ff >= CW'(CAPACITY));
      stat.pos_ok     = (pos_ff != 7'd0) &&
                        (PW'(pos_ff) <= PW'(len_ff) + PW'(1));
      stat.scan_done  = last_ff ||
                        (op_ff == 3'(ole_pkg::OP_REMOVE_VAL) && found_ff);
      stat.found      = found_ff;
      stat.shift_done = rd_ok_ff && (idx_ff == stop_ff);
   end

   // scan: idx_ff is next read address; data of idx_ff-1 arrives with rd_ok_ff.
   // shift down: read idx, write idx-1. shift up: read idx-1, write idx.
   logic [31:0] k_new, k_best;
   assign k_new  = rd_data ^ 32'h8000_0000;
   assign k_best = best_ff ^ 32'h8000_0000;

   always_comb begin
      idx_in   = idx_ff;
      hit_in   = hit_ff;
      best_in  = best_ff;
      found_in = found_ff;
      last_in  = last_ff;
      len_in   = len_ff;
      wr_en    = 1'b0;
      wr_addr  = AW'(idx_ff);
      wr_data  = rd_data;
      rd_addr  = AW'(idx_ff);
      if (cmd.scan_start) begin
         idx_in   = CW'(1);
         rd_addr  = '0;
         found_in = 1'b0;
         last_in  = 1'b0;
         hit_in   = '0;
      end else if (cmd.scan_step) begin
         rd_addr = AW'(idx_ff);
         if (idx_ff != len_ff) idx_in = idx_ff + CW'(1);
         // head removal only needs the first entry
         last_in = (idx_ff == len_ff) || (op_ff == 3'(ole_pkg::OP_HEAD_REMOVE));
         if (op_ff == 3'(ole_pkg::OP_REMOVE_VAL)) begin
            if (!found_ff && rd_data == val_ff) begin
               found_in = 1'b1;
               hit_in   = idx_ff - CW'(1);
            end
         end else if (idx_ff == CW'(1) ||
                      (op_ff == 3'(ole_pkg::OP_REMOVE_MAX) ? (k_new > k_best)
                                                           : (k_new < k_best))) begin
            best_in = rd_data;
            hit_in  = idx_ff - CW'(1);
         end
      end else if (cmd.down_start) begin
         // hit_ff holds the index to remove
         idx_in  = hit_ff + CW'(1);
         rd_addr = AW'(hit_ff + CW'(1));
      end else if (cmd.up_start) begin
         idx_in  = len_ff;
         rd_addr = AW'(len_ff - CW'(1));
      end else if (cmd.shift_step) begin
         if (op_ff == 3'(ole_pkg::OP_TAIL_INSERT) ||
             op_ff == 3'(ole_pkg::OP_POS_INSERT)) begin
            wr_en   = rd_ok_ff && (idx_ff != stop_ff);
            wr_addr = AW'(idx_ff);
            idx_in  = (wr_en) ? idx_ff - CW'(1) : idx_ff;
            rd_addr = AW'(idx_in - CW'(1));
         end else begin
            wr_en   = rd_ok_ff && (idx_ff != stop_ff);
            wr_addr = AW'(idx_ff - CW'(1));
            idx_in  = (wr_en) ? idx_ff + CW'(1) : idx_ff;
            rd_addr = AW'(idx_in);
         end
      end else if (cmd.write_new) begin
         wr_en   = 1'b1;
         wr_addr = AW'(stop_ff);
         wr_data = val_ff;
         len_in  = len_ff + CW'(1);
      end
      if (cmd.resp_load && cmd.status == ole_pkg::ST_OK && cmd.use_value &&
          op_ff != 3'(ole_pkg::OP_MIN)) begin
         len_in = len_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         rd_ok_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         len_ff   <= len_in;
         rd_ok_ff <= cmd.scan_start || cmd.down_start || cmd.up_start ||
                     cmd.scan_step || cmd.shift_step;
         last_ff  <= last_in;
      end
      idx_ff   <= idx_in;
      hit_ff   <= hit_in;
      best_ff  <= best_in;
      found_ff <= found_in;
      if (cmd.load) begin
         op_ff  <= req_operation;
         val_ff <= req_item_value;
         pos_ff <= req_position;
      end
      if (cmd.up_start) begin
         stop_ff <= (op_ff == 3'(ole_pkg::OP_POS_INSERT)) ? CW'(pos_ff - 7'd1) : len_ff;
      end else if (cmd.down_start) begin
         stop_ff <= len_ff;
      end
      if (cmd.resp_load) begin
         st_ff  <= cmd.status;
         res_ff <= !cmd.use_value ? 32'd0 :
                   (op_ff == 3'(ole_pkg::OP_REMOVE_VAL)) ? val_ff : best_ff;
      end
   end

   assign rsp_status       = st_ff;
   assign rsp_result_value = res_ff;
   assign rsp_entry_count  = 7'(len_ff);
endmodule
`default_nettype wire

// ===== src/ole_control.sv =====
`default_nettype none
module ole_control (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [2:0]        req_operation,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire ole_pkg::stat_type stat,
   output ole_pkg::cmd_type       cmd
);
   ole_pkg::state_type state_ff, state_in;
   logic [2:0] op_ff;
   logic       rv_ff, rv_in;
   logic       pending;  // request captured, first decision due
   logic       pend_ff;
   // outcome of the first decision, held until the result is loaded
   logic       ed_ff;
   logic [2:0] est_ff;

   logic accept;
   assign req_ready = (state_ff == ole_pkg::S_IDLE) && !pend_ff && (!rv_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rv_ff;

   logic ins, head_rm, scan_op;
   assign ins     = op_ff == 3'(ole_pkg::OP_TAIL_INSERT) ||
                    op_ff == 3'(ole_pkg::OP_POS_INSERT);
   assign head_rm = op_ff == 3'(ole_pkg::OP_HEAD_REMOVE);
   assign scan_op = op_ff == 3'(ole_pkg::OP_REMOVE_VAL) ||
                    op_ff == 3'(ole_pkg::OP_REMOVE_MAX) ||
                    op_ff == 3'(ole_pkg::OP_MIN);

   // first cycle after capture stays in S_IDLE with pend_ff high; decisions made there
   logic [2:0] early_st;
   logic       early_done;
   always_comb begin
      early_st   = ole_pkg::ST_OK;
      early_done = 1'b0;
      if (ins) begin
         if (stat.full) begin
            early_st = ole_pkg::ST_FULL; early_done = 1'b1;
         end else if (op_ff == 3'(ole_pkg::OP_POS_INSERT) && !stat.pos_ok) begin
            early_st = ole_pkg::ST_BADPOS; early_done = 1'b1;
         end
      end else if (head_rm || scan_op) begin
         if (stat.empty) begin
            early_st = ole_pkg::ST_EMPTY; early_done = 1'b1;
         end
      end else begin
         early_done = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ole_pkg::S_IDLE: begin
            if (pend_ff) begin
               if (early_done)   state_in = ole_pkg::S_RESP;
               else if (ins)     state_in = ole_pkg::S_SHIFT_UP;
               else              state_in = ole_pkg::S_SCAN;
            end
         end
         ole_pkg::S_SCAN: begin
            if (stat.scan_done) begin
               if (op_ff == 3'(ole_pkg::OP_MIN)) state_in = ole_pkg::S_RESP;
               else if (op_ff == 3'(ole_pkg::OP_REMOVE_VAL) && !stat.found)
                  state_in = ole_pkg::S_RESP;
               else state_in = ole_pkg::S_SHIFT_DOWN;
            end
         end
         ole_pkg::S_SHIFT_DOWN: if (stat.shift_done) state_in = ole_pkg::S_RESP;
         ole_pkg::S_SHIFT_UP:   if (stat.shift_done) state_in = ole_pkg::S_WRITE;
         ole_pkg::S_WRITE:      state_in = ole_pkg::S_RESP;
         ole_pkg::S_RESP:       state_in = ole_pkg::S_IDLE;
         default:               state_in = ole_pkg::S_IDLE;
      endcase
   end

   assign pending  = accept;

   always_comb begin
      cmd = '0;
      cmd.load = accept;
      case (state_ff)
         ole_pkg::S_IDLE: begin
            if (pend_ff && !early_done) begin
               cmd.scan_start = !ins;
               cmd.up_start   = ins;
            end
         end
         ole_pkg::S_SCAN: begin
            if (stat.scan_done) begin
               cmd.down_start = !(op_ff == 3'(ole_pkg::OP_MIN)) &&
                  !(op_ff == 3'(ole_pkg::OP_REMOVE_VAL) && !stat.found);
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ole_pkg::S_SHIFT_DOWN: cmd.shift_step = !stat.shift_done;
         ole_pkg::S_SHIFT_UP:   cmd.shift_step = !stat.shift_done;
         ole_pkg::S_WRITE:      cmd.write_new  = 1'b1;
         ole_pkg::S_RESP: begin
            cmd.resp_load = 1'b1;
            cmd.status    = est_ff;
            cmd.use_value = !ed_ff && !ins;
            if (op_ff == 3'(ole_pkg::OP_REMOVE_VAL) && !ed_ff && !stat.found) begin
               cmd.status    = ole_pkg::ST_NOTFOUND;
               cmd.use_value = 1'b0;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rv_in = rv_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      if (state_ff == ole_pkg::S_RESP) rv_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ole_pkg::S_IDLE;
         rv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         pend_ff  <= pending;
      end
      if (accept) op_ff <= req_operation;
      if (state_ff == ole_pkg::S_IDLE && pend_ff) begin
         ed_ff  <= early_done;
         est_ff <= early_st;
      end
   end
endmodule
`default_nettype wire

// ===== src/ordered_list_engine.sv =====
// Ordered list of signed 32-bit values, held packed in one RAM from the head.
// A rejected or trivial item goes straight to the result; a remove or query scans
// the list first, and an insert or removal shifts the entries behind the gap.
// One item in flight; the next is taken once the result register is free.
// Synchronous reset empties the list; RAM contents are not cleared.
`default_nettype none
module ordered_list_engine #(
   parameter int CAPACITY = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   ole_req_if.sink      req,
   ole_rsp_if.source    rsp
);
   ole_pkg::cmd_type  cmd;
   ole_pkg::stat_type stat;

   ole_control u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_operation(req.operation),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .cmd(cmd)
   );

   ole_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_operation(req.operation), .req_item_value(req.item_value),
      .req_position(req.position),
      .rsp_status(rsp.status), .rsp_result_value(rsp.result_value),
      .rsp_entry_count(rsp.entry_count)
   );
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 64;
   localparam int N_RANDOM = 1900;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_AT = 400;
   localparam int HOLD_LEN = 3000;
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0]         op;
      logic signed [31:0] val;
      logic [6:0]         pos;
   } list_req_type;

   typedef struct {
      logic [2:0]         status;
      logic signed [31:0] value;
      logic [6:0]         count;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ole_req_if req_ch ();
   ole_rsp_if rsp_ch ();

   ordered_list_engine #(.CAPACITY(CAP)) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   list_req_type       pending_reqs[$];
   list_rsp_type       expected_rsps[$];
   logic signed [31:0] shadow_list[$];
   int                 errors = 0;
   int                 n_accepted = 0;
   int                 n_results = 0;
   int                 status_hits[8];
   int                 peak_count = 0;
   bit                 stim_done = 1'b0;

   // shadow copy of the list, updated per accepted item
   function automatic list_rsp_type apply_to_list(list_req_type r);
      list_rsp_type       o;
      int                 idx;
      logic signed [31:0] best;
      o.status = ole_pkg::ST_OK;
      o.value = '0;
      idx = -1;
      case (r.op)
         ole_pkg::OP_TAIL_INSERT:
            if (shadow_list.size() >= CAP) o.status = ole_pkg::ST_FULL;
            else shadow_list.push_back(r.val);
         ole_pkg::OP_HEAD_REMOVE:
            if (shadow_list.size() == 0) o.status = ole_pkg::ST_EMPTY;
            else o.value = shadow_list.pop_front();
         ole_pkg::OP_POS_INSERT:
            if (shadow_list.size() >= CAP) o.status = ole_pkg::ST_FULL;
            else if (r.pos < 1 || r.pos > shadow_list.size() + 1)
               o.status = ole_pkg::ST_BADPOS;
            else shadow_list.insert(r.pos - 1, r.val);
         ole_pkg::OP_REMOVE_VAL:
            if (shadow_list.size() == 0) o.status = ole_pkg::ST_EMPTY;
            else begin
               for (int i = 0; i < shadow_list.size(); i++)
                  if (idx < 0 && shadow_list[i] == r.val) idx = i;
               if (idx < 0) o.status = ole_pkg::ST_NOTFOUND;
               else begin
                  o.value = shadow_list[idx];
                  shadow_list.delete(idx);
               end
            end
         ole_pkg::OP_REMOVE_MAX, ole_pkg::OP_MIN:
            if (shadow_list.size() == 0) o.status = ole_pkg::ST_EMPTY;
            else begin
               idx = 0;
               best = shadow_list[0];
               for (int i = 1; i < shadow_list.size(); i++)
                  if (r.op == ole_pkg::OP_REMOVE_MAX ? shadow_list[i] > best
                                                     : shadow_list[i] < best) begin
                     idx = i;
                     best = shadow_list[i];
                  end
               o.value = best;
               if (r.op == ole_pkg::OP_REMOVE_MAX) shadow_list.delete(idx);
            end
         default: ;
      endcase
      o.count = 7'(shadow_list.size());
      if (shadow_list.size() > peak_count) peak_count = shadow_list.size();
      return o;
   endfunction

   function automatic void add_req(logic [2:0] op, logic signed [31:0] val, logic [6:0] pos);
      list_req_type r;
      r.op = op;
      r.val = val;
      r.pos = pos;
      pending_reqs.push_back(r);
   endfunction

   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return $signed($urandom_range(0, 15)) - 8;
      if (sel == 5) return 32'sh8000_0000 + $urandom_range(0, 2);
      if (sel == 6) return 32'sh7fff_ffff - $urandom_range(0, 2);
      return $urandom;
   endfunction

   // driver
   list_req_type cur_req;
   int           req_gap = 0;
   bit           req_burst = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            expected_rsps.push_back(apply_to_list(cur_req));
            n_accepted++;
         end
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.operation <= cur_req.op;
            req_ch.item_value <= cur_req.val;
            req_ch.position <= cur_req.pos;
            if ($urandom_range(0, 59) == 0) req_burst = !req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 17);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver and checker
   int  rsp_gap = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  rsp_burst = 1'b0;
   list_rsp_type got, want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status = rsp_ch.status;
            got.value = rsp_ch.result_value;
            got.count = rsp_ch.entry_count;
            n_results++;
            status_hits[got.status]++;
            if (expected_rsps.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected item: status %0d value %0d count %0d",
                           got.status, got.value, got.count);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status || got.value !== want.value ||
                   got.count !== want.count) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch on item %0d: exp st %0d val %0d cnt %0d,",
                               " got st %0d val %0d cnt %0d"},
                              n_results, want.status, want.value, want.count,
                              got.status, got.value, got.count);
               end
            end
            if ($urandom_range(0, 59) == 0) rsp_burst = !rsp_burst;
            rsp_gap = rsp_burst ? 0 : $urandom_range(0, 17);
            if (!hold_done && n_results >= HOLD_AT) begin
               hold_left = HOLD_LEN;
               hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int grow;
      int n;
      int op_pick;
      req_ch.valid = 1'b0;
      req_ch.operation = '0;
      req_ch.item_value = '0;
      req_ch.position = '0;
      rsp_ch.ready = 1'b0;

      // empty list cases, bad positions, extremes, ties, spare codes
      add_req(ole_pkg::OP_MIN, 32'sd5, 7'd1);
      add_req(ole_pkg::OP_HEAD_REMOVE, 32'sd0, 7'd0);
      add_req(ole_pkg::OP_REMOVE_VAL, 32'sd3, 7'd0);
      add_req(ole_pkg::OP_REMOVE_MAX, 32'sd0, 7'd0);
      add_req(ole_pkg::OP_POS_INSERT, 32'sd9, 7'd0);
      add_req(ole_pkg::OP_POS_INSERT, 32'sd9, 7'd2);
      add_req(ole_pkg::OP_POS_INSERT, 32'sd9, 7'd1);
      add_req(ole_pkg::OP_TAIL_INSERT, 32'sh8000_0000, 7'd127);
      add_req(ole_pkg::OP_TAIL_INSERT, 32'sh7fff_ffff, 7'd0);
      add_req(ole_pkg::OP_TAIL_INSERT, -32'sd1, 7'd0);
      add_req(ole_pkg::OP_POS_INSERT, 32'sh7fff_ffff, 7'd3);
      add_req(ole_pkg::OP_POS_INSERT, 32'sh8000_0000, 7'd6);
      add_req(ole_pkg::OP_POS_INSERT, 32'sd0, 7'd7);
      add_req(ole_pkg::OP_POS_INSERT, 32'sd1, 7'd127);
      add_req(ole_pkg::OP_MIN, 32'sd0, 7'd0);
      add_req(OP_SPARE_LO, 32'sh7fff_ffff, 7'd127);
      add_req(OP_SPARE_HI, -32'sd1, 7'd1);
      add_req(ole_pkg::OP_REMOVE_MAX, 32'sd0, 7'd0);
      add_req(ole_pkg::OP_REMOVE_MAX, 32'sd0, 7'd0);
      add_req(ole_pkg::OP_REMOVE_VAL, 32'sh8000_0000, 7'd0);
      add_req(ole_pkg::OP_REMOVE_VAL, 32'sh8000_0000, 7'd0);
      add_req(ole_pkg::OP_REMOVE_VAL, 32'sd42, 7'd0);
      add_req(ole_pkg::OP_HEAD_REMOVE, 32'sd0, 7'd0);

      // randomly chosen grow and shrink phases to drive the list toward full and empty
      n = 0;
      while (n < N_RANDOM) begin
         grow = $urandom_range(0, 1);
         repeat ($urandom_range(20, 120)) begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < 2)
               add_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom,
                       7'($urandom));
            else if (grow ? op_pick < 50 : op_pick < 14)
               add_req(ole_pkg::OP_TAIL_INSERT, pick_value(), 7'($urandom));
            else if (grow ? op_pick < 80 : op_pick < 25)
               add_req(ole_pkg::OP_POS_INSERT, pick_value(),
                       7'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 66)));
            else begin
               case ($urandom_range(0, 3))
                  0: add_req(ole_pkg::OP_HEAD_REMOVE, $urandom, 7'($urandom));
                  1: add_req(ole_pkg::OP_REMOVE_VAL, pick_value(), 7'($urandom));
                  2: add_req(ole_pkg::OP_REMOVE_MAX, $urandom, 7'($urandom));
                  default: add_req(ole_pkg::OP_MIN, $urandom, 7'($urandom));
               endcase
            end
            n++;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() == 0 && !req_ch.valid);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("%0d items in, %0d results out; peak list length %0d of %0d",
               n_accepted, n_results, peak_count, CAP);
      $display("status counts: ok %0d empty %0d full %0d badpos %0d notfound %0d, %0d errors",
               status_hits[ole_pkg::ST_OK], status_hits[ole_pkg::ST_EMPTY],
               status_hits[ole_pkg::ST_FULL], status_hits[ole_pkg::ST_BADPOS],
               status_hits[ole_pkg::ST_NOTFOUND], errors);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
